>>> rtl/open_address_hash_table_engine_unit_defines.svh
// Assertion macros shared by the hash table engine RTL.
// No dependencies; included by modules that carry assertions.
`ifndef OPEN_ADDRESS_HASH_TABLE_ENGINE_UNIT_DEFINES_SVH
`define OPEN_ADDRESS_HASH_TABLE_ENGINE_UNIT_DEFINES_SVH

// Checked at every rising clock edge outside reset.
`define OAHT_ASSERT(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) else $error(msg);

// Implication whose consequent is checked in the cycle after the antecedent, outside reset.
`define OAHT_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/oaht_pkg.sv
// Shared types, constants and a helper function for the hash table engine.
// No dependencies.
package oaht_pkg;

    localparam int MAX_SLOTS_DEF  = 1024;
    localparam int MIN_SLOTS_DEF  = 16;
    localparam int KEY_BITS_DEF   = 32;
    localparam int INDEX_BITS_DEF = 16;

    localparam int MODE_W  = 3;
    localparam int HASH_W  = 32;
    localparam int KEY_W   = 32;
    localparam int IDX_W   = 16;
    localparam int CNT_W   = 11;
    localparam int STAT_W  = 3;
    localparam int STEP_W  = 5;
    localparam int NUM_STEPS = 8;
    localparam int STEP_SEL_W = $clog2(NUM_STEPS);
    localparam int TAG_W   = 2;

    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = $clog2(QDEPTH);

    localparam int IN_TDATA_W  = 96;
    localparam int OUT_TDATA_W = 48;

    // mode codes on the input
    localparam logic [MODE_W-1:0] MODE_REBUILD_START  = 3'd0;
    localparam logic [MODE_W-1:0] MODE_REBUILD_INSERT = 3'd1;
    localparam logic [MODE_W-1:0] MODE_INSERT         = 3'd2;
    localparam logic [MODE_W-1:0] MODE_DELETE         = 3'd3;
    localparam logic [MODE_W-1:0] MODE_FIND           = 3'd4;

    typedef enum logic [2:0] {
        OP_REBUILD_START,
        OP_REBUILD_INSERT,
        OP_INSERT,
        OP_DELETE,
        OP_FIND,
        OP_NOP
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE     = 3'd0,
        STAT_HIT      = 3'd1,
        STAT_MISS     = 3'd2,
        STAT_REBUILD  = 3'd3,
        STAT_NO_TABLE = 3'd4
    } t_status;

    typedef enum logic [TAG_W-1:0] {
        TAG_CLEAN   = 2'd0,
        TAG_DELETED = 2'd1,
        TAG_USED    = 2'd2
    } t_tag;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CLEAR,
        ST_PROBE,
        ST_EVAL
    } t_state;

    typedef struct packed {
        t_op                op;
        logic [HASH_W-1:0]  hash;
        logic [KEY_W-1:0]   key;
        logic [IDX_W-1:0]   idx;
        logic [CNT_W-1:0]   count;
        logic [STEP_W-1:0]  step;
    } t_item;

    function automatic logic [STEP_W-1:0] step_prime(input logic [STEP_SEL_W-1:0] sel);
        logic [STEP_W-1:0] p;
        case (sel)
            3'd0:    p = 5'd3;
            3'd1:    p = 5'd5;
            3'd2:    p = 5'd7;
            3'd3:    p = 5'd11;
            3'd4:    p = 5'd13;
            3'd5:    p = 5'd17;
            3'd6:    p = 5'd19;
            3'd7:    p = 5'd23;
            default: p = 5'd3;
        endcase
        return p;
    endfunction

endpackage

>>> rtl/open_address_hash_table_engine_unit.sv
// Hash table engine with open addressing and double hashing: stream
// channels, APB enable register, front decoder/queue and back probe engine.
// Depends on oaht_pkg, oaht_front, oaht_back.
//
// Input stream carries one operation per transfer (mode in tuser); output
// stream returns exactly one result per operation, in order (status in tuser).
// Operations: rebuild start (size and clear), rebuild insert, insert, delete
// and find. The front queues up to two operations, so transfers are taken
// while the probe engine works or while a result waits on a stalled receiver.
// The engine runs one operation at a time. An operation decided without
// probing reads no slot; each probe takes one slot memory read and one
// compare, and a rebuild start of S slots clears the table one slot a
// cycle. The next operation is popped the cycle after the result transfer.
// A held result stalls the engine but not the input queue. Reset leaves
// no table present (every operation but rebuild start and an unknown
// mode answers no_table), the enable register set and no slot memory
// clearing pass.
module open_address_hash_table_engine_unit #(
    parameter int MAX_SLOTS  = oaht_pkg::MAX_SLOTS_DEF,
    parameter int MIN_SLOTS  = oaht_pkg::MIN_SLOTS_DEF,
    parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF,
    parameter int INDEX_BITS = oaht_pkg::INDEX_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // hash_value[31:0], lookup_key[63:32], store_index[79:64], entry_count[90:80]
    input  logic [oaht_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    // mode[2:0]
    input  logic [oaht_pkg::MODE_W-1:0]      i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // found_index[15:0], found_key[47:16]
    output logic [oaht_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // status[2:0]
    output logic [oaht_pkg::STAT_W-1:0]      o_m_axis_tuser,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam logic [2:0] ADDR_TABLE_ENABLE = 3'd0;

    logic            r_table_enable;
    logic            q_pop;
    logic            q_valid;
    oaht_pkg::t_item q_item;
    logic [oaht_pkg::IDX_W-1:0] found_index;
    logic [oaht_pkg::KEY_W-1:0] found_key;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_TABLE_ENABLE) ? {31'd0, r_table_enable} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_table_enable <= 1'b1;
        end else if (psel && penable && pwrite && pready && paddr == ADDR_TABLE_ENABLE) begin
            r_table_enable <= pwdata[0];
        end
    end

    oaht_front #(
        .KEY_BITS   (KEY_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (o_s_axis_tready),
        .i_mode  (i_s_axis_tuser),
        .i_hash  (i_s_axis_tdata[31:0]),
        .i_key   (i_s_axis_tdata[63:32]),
        .i_idx   (i_s_axis_tdata[79:64]),
        .i_count (i_s_axis_tdata[90:80]),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    oaht_back #(
        .MAX_SLOTS  (MAX_SLOTS),
        .MIN_SLOTS  (MIN_SLOTS),
        .KEY_BITS   (KEY_BITS),
        .INDEX_BITS (INDEX_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_table_enable (r_table_enable),
        .i_valid        (q_valid),
        .i_item         (q_item),
        .o_pop          (q_pop),
        .o_out_valid    (o_m_axis_tvalid),
        .i_out_ready    (i_m_axis_tready),
        .o_status       (o_m_axis_tuser),
        .o_found_index  (found_index),
        .o_found_key    (found_key)
    );

    assign o_m_axis_tdata = {found_key, found_index};

endmodule

>>> rtl/oaht_fifo.sv
// Two-entry item queue between the front decoder and the probe engine.
// Depends on oaht_pkg.
module oaht_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  oaht_pkg::t_item i_item,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output oaht_pkg::t_item o_item
);

    localparam int CW = oaht_pkg::QPTR_W + 1;

    oaht_pkg::t_item r_q [oaht_pkg::QDEPTH];
    logic [oaht_pkg::QPTR_W-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_count;

    assign o_full  = (r_count == CW'(oaht_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_q[r_rptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wptr <= r_wptr + 1'b1;
            end
            if (i_pop) begin
                r_rptr <= r_rptr + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_q[r_wptr] <= i_item;
        end
    end

endmodule

>>> rtl/oaht_front.sv
// Front end: accepts stream transfers, classifies the operation, picks the
// probe step and queues the item. Depends on oaht_pkg and oaht_fifo.
module oaht_front #(
    parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF,
    parameter int INDEX_BITS = oaht_pkg::INDEX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [oaht_pkg::MODE_W-1:0]  i_mode,
    input  logic [oaht_pkg::HASH_W-1:0]  i_hash,
    input  logic [oaht_pkg::KEY_W-1:0]   i_key,
    input  logic [oaht_pkg::IDX_W-1:0]   i_idx,
    input  logic [oaht_pkg::CNT_W-1:0]   i_count,
    input  logic                         i_pop,
    output logic                         o_valid,
    output oaht_pkg::t_item              o_item
);

    logic            full;
    logic            push;
    oaht_pkg::t_item item;

    assign o_ready = !full;
    assign push    = i_valid && !full;

    always_comb begin
        case (i_mode)
            oaht_pkg::MODE_REBUILD_START:  item.op = oaht_pkg::OP_REBUILD_START;
            oaht_pkg::MODE_REBUILD_INSERT: item.op = oaht_pkg::OP_REBUILD_INSERT;
            oaht_pkg::MODE_INSERT:         item.op = oaht_pkg::OP_INSERT;
            oaht_pkg::MODE_DELETE:         item.op = oaht_pkg::OP_DELETE;
            oaht_pkg::MODE_FIND:           item.op = oaht_pkg::OP_FIND;
            default:                       item.op = oaht_pkg::OP_NOP;
        endcase
        item.hash  = i_hash;
        // only the low key and index bits are stored or compared
        item.key   = i_key & oaht_pkg::KEY_W'((64'd1 << KEY_BITS) - 64'd1);
        item.idx   = i_idx & oaht_pkg::IDX_W'((32'd1 << INDEX_BITS) - 32'd1);
        item.count = i_count;
        item.step  = oaht_pkg::step_prime(i_hash[oaht_pkg::STEP_SEL_W-1:0]);
    end

    oaht_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (item),
        .o_full  (full),
        .i_pop   (i_pop),
        .o_valid (o_valid),
        .o_item  (o_item)
    );

endmodule

>>> rtl/oaht_back.sv
// Back end: slot memory, counters and the probe sequencer; holds the result
// register. Depends on oaht_pkg and the assertion macro header.
`include "open_address_hash_table_engine_unit_defines.svh"

module oaht_back #(
    parameter int MAX_SLOTS  = oaht_pkg::MAX_SLOTS_DEF,
    parameter int MIN_SLOTS  = oaht_pkg::MIN_SLOTS_DEF,
    parameter int KEY_BITS   = oaht_pkg::KEY_BITS_DEF,
    parameter int INDEX_BITS = oaht_pkg::INDEX_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_table_enable,
    input  logic                         i_valid,
    input  oaht_pkg::t_item              i_item,
    output logic                         o_pop,
    output logic                         o_out_valid,
    input  logic                         i_out_ready,
    output logic [oaht_pkg::STAT_W-1:0]  o_status,
    output logic [oaht_pkg::IDX_W-1:0]   o_found_index,
    output logic [oaht_pkg::KEY_W-1:0]   o_found_key
);

    localparam int AW     = $clog2(MAX_SLOTS);
    localparam int SZ_W   = AW + 1;
    localparam int LG_W   = $clog2(AW + 1);
    localparam int MINL   = $clog2(MIN_SLOTS);
    localparam int NEED_W = oaht_pkg::CNT_W + 1;
    localparam int CW     = (SZ_W > NEED_W) ? SZ_W : NEED_W;
    localparam int SLOT_W = oaht_pkg::TAG_W + KEY_BITS + INDEX_BITS;
    localparam int HALF_MIN = MIN_SLOTS / 2;

    typedef logic [oaht_pkg::STAT_W-1:0] t_status_l;

    logic [SLOT_W-1:0] r_mem [MAX_SLOTS];
    logic [SLOT_W-1:0] r_rd;

    oaht_pkg::t_state r_state, n_state;
    oaht_pkg::t_item  r_item, n_item;
    logic [LG_W-1:0]  r_size_log2, n_size_log2;
    logic [SZ_W-1:0]  r_clean, n_clean;
    logic [SZ_W-1:0]  r_unused, n_unused;
    logic [SZ_W-1:0]  r_old_unused, n_old_unused;
    logic             r_present, n_present;
    logic [AW-1:0]    r_pos, n_pos;
    logic [SZ_W-1:0]  r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    t_status_l        r_status, n_status;
    logic [oaht_pkg::IDX_W-1:0] r_fidx, n_fidx;
    logic [oaht_pkg::KEY_W-1:0] r_fkey, n_fkey;
    // in the cycle after a pop the item sits in r_item and is dispatched
    logic             r_pending;

    logic              mem_we;
    logic [AW-1:0]     mem_addr;
    logic [SLOT_W-1:0] mem_wdata;

    logic [SZ_W-1:0]     size;
    logic [AW-1:0]       mask;
    logic [NEED_W-1:0]   need;
    logic [LG_W-1:0]     new_log2;
    logic [CW-1:0]       new_size;
    logic [SZ_W-1:0]     del_inc;
    logic [SZ_W+1:0]     del_limit;
    logic [AW+oaht_pkg::STEP_W-1:0] pos_sum;
    logic [AW-1:0]       next_pos;
    logic [SZ_W-1:0]     cnt_inc;
    oaht_pkg::t_tag      rd_tag;
    logic [KEY_BITS-1:0]   rd_key;
    logic [INDEX_BITS-1:0] rd_idx;
    logic [SLOT_W-1:0]   wr_used;

    assign size      = SZ_W'(1) << r_size_log2;
    assign mask      = AW'(size - 1'b1);
    assign need      = NEED_W'(r_item.count) + NEED_W'(r_item.count >> 1);
    assign del_inc   = (r_unused < size) ? r_unused + 1'b1 : r_unused;
    assign del_limit = ((SZ_W+2)'(size) + ((SZ_W+2)'(size) << 1)) >> 2;
    assign pos_sum   = (AW+oaht_pkg::STEP_W)'(r_pos) + (AW+oaht_pkg::STEP_W)'(r_item.step);
    assign next_pos  = pos_sum[AW-1:0] & mask;
    assign cnt_inc   = r_cnt + 1'b1;
    assign rd_tag    = oaht_pkg::t_tag'(r_rd[SLOT_W-1 -: oaht_pkg::TAG_W]);
    assign rd_key    = r_rd[INDEX_BITS +: KEY_BITS];
    assign rd_idx    = r_rd[INDEX_BITS-1:0];
    assign wr_used   = {oaht_pkg::TAG_USED, r_item.key[KEY_BITS-1:0],
                        r_item.idx[INDEX_BITS-1:0]};

    // smallest power of two at or above the need, not below the minimum size
    always_comb begin
        new_log2 = LG_W'(AW);
        for (int k = AW; k >= MINL; k--) begin
            if ((CW'(1) << k) >= CW'(need)) begin
                new_log2 = LG_W'(k);
            end
        end
        new_size = CW'(1) << new_log2;
    end

    assign o_pop = (r_state == oaht_pkg::ST_IDLE) && i_valid && !r_out_valid && !r_pending;

    always_comb begin
        n_state      = r_state;
        n_item       = r_item;
        n_size_log2  = r_size_log2;
        n_clean      = r_clean;
        n_unused     = r_unused;
        n_old_unused = r_old_unused;
        n_present    = r_present;
        n_pos        = r_pos;
        n_cnt        = r_cnt;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_status     = r_status;
        n_fidx       = r_fidx;
        n_fkey       = r_fkey;
        mem_we       = 1'b0;
        mem_addr     = r_pos;
        mem_wdata    = wr_used;

        case (r_state)
            oaht_pkg::ST_IDLE: begin
                if (o_pop) begin
                    n_item = i_item;
                    n_fidx = '0;
                    n_fkey = '0;
                    n_pos  = i_item.hash[AW-1:0] & mask;
                    n_cnt  = '0;
                end
            end
            oaht_pkg::ST_CLEAR: begin
                mem_we    = 1'b1;
                mem_wdata = '0;
                if (r_pos == mask) begin
                    n_present   = 1'b1;
                    n_out_valid = 1'b1;
                    n_status    = oaht_pkg::STAT_DONE;
                    n_state     = oaht_pkg::ST_IDLE;
                end else begin
                    n_pos = r_pos + 1'b1;
                end
            end
            oaht_pkg::ST_PROBE: begin
                // read of r_pos lands in r_rd next cycle
                n_state = oaht_pkg::ST_EVAL;
            end
            oaht_pkg::ST_EVAL: begin
                n_cnt   = cnt_inc;
                n_pos   = next_pos;
                n_state = oaht_pkg::ST_PROBE;
                case (r_item.op)
                    oaht_pkg::OP_DELETE: begin
                        if (rd_tag == oaht_pkg::TAG_USED && rd_idx == r_item.idx[INDEX_BITS-1:0]) begin
                            mem_we      = 1'b1;
                            mem_wdata   = {oaht_pkg::TAG_DELETED, rd_key, rd_idx};
                            n_pos       = r_pos;
                            n_status    = oaht_pkg::STAT_DONE;
                            n_out_valid = 1'b1;
                            n_state     = oaht_pkg::ST_IDLE;
                        end else if (cnt_inc == size) begin
                            n_unused    = r_old_unused;
                            n_status    = oaht_pkg::STAT_MISS;
                            n_out_valid = 1'b1;
                            n_state     = oaht_pkg::ST_IDLE;
                        end
                    end
                    oaht_pkg::OP_FIND: begin
                        if (rd_tag == oaht_pkg::TAG_CLEAN) begin
                            n_status    = oaht_pkg::STAT_MISS;
                            n_out_valid = 1'b1;
                            n_state     = oaht_pkg::ST_IDLE;
                        end else if (rd_tag == oaht_pkg::TAG_USED &&
                                     rd_key == r_item.key[KEY_BITS-1:0]) begin
                            n_status    = oaht_pkg::STAT_HIT;
                            n_fidx      = oaht_pkg::IDX_W'(rd_idx);
                            n_fkey      = oaht_pkg::KEY_W'(rd_key);
                            n_out_valid = 1'b1;
                            n_state     = oaht_pkg::ST_IDLE;
                        end else if (cnt_inc == size) begin
                            n_status    = oaht_pkg::STAT_MISS;
                            n_out_valid = 1'b1;
                            n_state     = oaht_pkg::ST_IDLE;
                        end
                    end
                    default: begin
                        // both insert flavors take the first free slot
                        if (rd_tag != oaht_pkg::TAG_USED) begin
                            mem_we = 1'b1;
                            if (r_item.op == oaht_pkg::OP_INSERT) begin
                                if (rd_tag == oaht_pkg::TAG_CLEAN && r_clean != '0) begin
                                    n_clean = r_clean - 1'b1;
                                end
                                if (r_unused != '0) begin
                                    n_unused = r_unused - 1'b1;
                                end
                            end
                            n_pos       = r_pos;
                            n_status    = oaht_pkg::STAT_DONE;
                            n_out_valid = 1'b1;
                            n_state     = oaht_pkg::ST_IDLE;
                        end else if (cnt_inc == size) begin
                            n_status    = oaht_pkg::STAT_REBUILD;
                            n_out_valid = 1'b1;
                            n_state     = oaht_pkg::ST_IDLE;
                        end
                    end
                endcase
            end
            default: n_state = oaht_pkg::ST_IDLE;
        endcase

        // decision for a newly popped item, taken from registered item next cycle
        if (r_state == oaht_pkg::ST_IDLE && r_pending) begin
            case (r_item.op)
                oaht_pkg::OP_REBUILD_START: begin
                    n_present = 1'b0;
                    if (!i_table_enable || r_item.count < oaht_pkg::CNT_W'(HALF_MIN) ||
                        new_size < CW'(need)) begin
                        n_status    = oaht_pkg::STAT_NO_TABLE;
                        n_out_valid = 1'b1;
                    end else begin
                        n_size_log2 = new_log2;
                        n_clean     = SZ_W'(new_size - CW'(r_item.count));
                        n_unused    = SZ_W'(new_size - CW'(r_item.count));
                        n_pos       = '0;
                        n_state     = oaht_pkg::ST_CLEAR;
                    end
                end
                oaht_pkg::OP_NOP: begin
                    n_status    = oaht_pkg::STAT_DONE;
                    n_out_valid = 1'b1;
                end
                default: begin
                    if (!r_present) begin
                        n_status    = oaht_pkg::STAT_NO_TABLE;
                        n_out_valid = 1'b1;
                    end else if (r_item.op == oaht_pkg::OP_INSERT && r_clean < (size >> 3)) begin
                        n_status    = oaht_pkg::STAT_REBUILD;
                        n_out_valid = 1'b1;
                    end else if (r_item.op == oaht_pkg::OP_DELETE) begin
                        n_unused     = del_inc;
                        n_old_unused = r_unused;
                        if ((SZ_W+2)'(del_inc) > del_limit) begin
                            n_status    = oaht_pkg::STAT_REBUILD;
                            n_out_valid = 1'b1;
                        end else begin
                            n_state = oaht_pkg::ST_PROBE;
                        end
                    end else begin
                        n_state = oaht_pkg::ST_PROBE;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= oaht_pkg::ST_IDLE;
            r_size_log2 <= LG_W'(MINL);
            r_clean     <= '0;
            r_unused    <= '0;
            r_present   <= 1'b0;
            r_out_valid <= 1'b0;
            r_pending   <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_size_log2 <= n_size_log2;
            r_clean     <= n_clean;
            r_unused    <= n_unused;
            r_present   <= n_present;
            r_out_valid <= n_out_valid;
            r_pending   <= o_pop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item       <= n_item;
        r_old_unused <= n_old_unused;
        r_pos        <= n_pos;
        r_cnt        <= n_cnt;
        r_status     <= n_status;
        r_fidx       <= n_fidx;
        r_fkey       <= n_fkey;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rd <= r_mem[r_pos];
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_status;
    assign o_found_index = r_fidx;
    assign o_found_key   = r_fkey;

    `OAHT_ASSERT(a_clean_le_size, !r_present || r_clean <= size, "clean count above table size")
    `OAHT_ASSERT(a_unused_le_size, !r_present || r_unused <= size, "unused count above table size")
    `OAHT_ASSERT(a_eval_bound, r_state != oaht_pkg::ST_EVAL || r_cnt < size, "probe ran past table size")
    `OAHT_ASSERT_NEXT(a_pop_dispatch, o_pop, r_pending && !r_out_valid, "popped item not dispatched")

endmodule
